/* hw/rtl/bhsc_pkg.sv */
// ----------------------------------------------------------------------------
// BLDC hall commutator package
// Shared types, register indexes, mode codes and the six-step drive table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bhsc_pkg;

   // Configuration port sizes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_PERCENT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_LIMIT  = 3'd4;

   // Configuration reset values.
   localparam logic        RST_DIRECTION    = 1'b0;
   localparam logic [6:0]  RST_DUTY_PERCENT = 7'd40;
   localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;
   localparam logic [7:0]  RST_START_LIMIT  = 8'd20;
   localparam logic [15:0] RST_STALL_LIMIT  = 16'd2000;

   // Period times duty is at most 65535 * 127, which fits in 23 bits.
   localparam int PRODUCT_W = 23;
   localparam logic [PRODUCT_W-1:0] RST_PRODUCT = 23'd40000;

   // Division by 100 as a multiply by ceil(2^30 / 100) and a shift by 30.
   // Exact for every 23-bit dividend.
   localparam int              RECIP_SHIFT = 30;
   localparam logic [23:0]     RECIP_100   = 24'd10737419;

   // Motor modes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;

   // Request kinds.
   localparam logic REQ_CONTROL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // Hall code held after reset.
   localparam logic [2:0] RST_LAST_HALL = 3'd1;

   // Phase drive bit positions.
   localparam int DRV_UH = 0;
   localparam int DRV_UL = 1;
   localparam int DRV_VH = 2;
   localparam int DRV_VL = 3;
   localparam int DRV_WH = 4;
   localparam int DRV_WL = 5;

   // One input transfer.
   typedef struct packed {
      logic       req_type;
      logic [2:0] hall_code;
   } bhsc_req_item_type;

   // One result transfer.
   typedef struct packed {
      logic        drive_u_high;
      logic        drive_u_low;
      logic        drive_v_high;
      logic        drive_v_low;
      logic        drive_w_high;
      logic        drive_w_low;
      logic        gate_enable;
      logic [15:0] duty_compare;
      logic [1:0]  motor_mode;
   } bhsc_rsp_item_type;

   // Settings handed from the register file to the core.
   typedef struct packed {
      logic        direction;
      logic [7:0]  start_limit;
      logic [15:0] stall_limit;
      logic [15:0] compare;
   } bhsc_cfg_type;

   // Six-step drive pattern for a hall code; codes 0 and 7 switch all off.
   function automatic logic [5:0] six_step(input logic [2:0] sel);
      logic [5:0] drv;
      drv = '0;
      case (sel)
         3'd1: begin drv[DRV_UH] = 1'b1; drv[DRV_WL] = 1'b1; end
         3'd2: begin drv[DRV_VH] = 1'b1; drv[DRV_UL] = 1'b1; end
         3'd3: begin drv[DRV_VH] = 1'b1; drv[DRV_WL] = 1'b1; end
         3'd4: begin drv[DRV_WH] = 1'b1; drv[DRV_VL] = 1'b1; end
         3'd5: begin drv[DRV_UH] = 1'b1; drv[DRV_VL] = 1'b1; end
         3'd6: begin drv[DRV_WH] = 1'b1; drv[DRV_UL] = 1'b1; end
         default: drv = '0;
      endcase
      return drv;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bldc_hall_six_step_commutator.sv */
// ----------------------------------------------------------------------------
// BLDC hall six-step commutator
// Start, run and stop control of a three-phase bridge from hall sensors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Ports                              Transfer when
//   req       in          req_valid, req_stall, req_data      valid && !stall
//   rsp       out         rsp_valid, rsp_stall, rsp_data      valid && !stall
//   csr       in          csr_write, csr_index, csr_data      csr_write
//
// Every request gives one response, and a new request can be taken in every
// cycle while the response is not stalled; the state update is a single pass
// from the input register into the state register, which is the result.
// Synchronous reset returns the motor to start with the default settings.
// A stalled response holds; the input register still takes one more request
// before req_stall rises.
//
`timescale 1ns / 1ps
`default_nettype none

module bldc_hall_six_step_commutator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire bhsc_pkg::bhsc_req_item_type      req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output bhsc_pkg::bhsc_rsp_item_type           rsp_data,
   input  wire logic                             csr_write,
   input  wire logic [bhsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bhsc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bhsc_pkg::*;

   bhsc_cfg_type      cfg;
   logic              in_valid_ff;
   bhsc_req_item_type in_data_ff;
   logic              item_take;

   // The input register is held while it is full and the core cannot take it.
   assign req_stall = in_valid_ff && !item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   bhsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bhsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (in_valid_ff),
      .item       (in_data_ff),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/bhsc_csr.sv */
// ----------------------------------------------------------------------------
// BLDC hall commutator register file
// Holds the configuration registers and the scaled PWM compare value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhsc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [bhsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bhsc_pkg::CSR_DATA_W-1:0]  csr_data,
   output bhsc_pkg::bhsc_cfg_type               cfg
);
   import bhsc_pkg::*;

   logic                 direction_ff;
   logic [6:0]           duty_ff;
   logic [15:0]          period_ff;
   logic [7:0]           start_limit_ff;
   logic [15:0]          stall_limit_ff;
   logic [PRODUCT_W-1:0] product_ff;
   logic [PRODUCT_W-1:0] product_in;

   logic [PRODUCT_W+23:0] quot_wide;
   logic [16:0]           quot;

   // The period-duty product is formed when either operand is written, so
   // it is ready in its register by the time an item can arrive.
   always_comb begin
      product_in = product_ff;
      if (csr_write && csr_index == CSR_DUTY_PERCENT) begin
         product_in = PRODUCT_W'(period_ff * csr_data[6:0]);
      end else if (csr_write && csr_index == CSR_PWM_PERIOD) begin
         product_in = PRODUCT_W'(csr_data * duty_ff);
      end
   end

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= RST_DIRECTION;
         duty_ff        <= RST_DUTY_PERCENT;
         period_ff      <= RST_PWM_PERIOD;
         start_limit_ff <= RST_START_LIMIT;
         stall_limit_ff <= RST_STALL_LIMIT;
         product_ff     <= RST_PRODUCT;
      end else begin
         product_ff <= product_in;
         if (csr_write) begin
            case (csr_index)
               CSR_DIRECTION:    direction_ff   <= csr_data[0];
               CSR_DUTY_PERCENT: duty_ff        <= csr_data[6:0];
               CSR_PWM_PERIOD:   period_ff      <= csr_data;
               CSR_START_LIMIT:  start_limit_ff <= csr_data[7:0];
               CSR_STALL_LIMIT:  stall_limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Product over 100 by reciprocal multiply, saturated to 16 bits.
   always_comb begin
      quot_wide = (PRODUCT_W+24)'(product_ff) * (PRODUCT_W+24)'(RECIP_100);
      quot      = quot_wide[RECIP_SHIFT+16:RECIP_SHIFT];
   end

   always_comb begin
      cfg.direction   = direction_ff;
      cfg.start_limit = start_limit_ff;
      cfg.stall_limit = stall_limit_ff;
      cfg.compare     = quot[16] ? 16'hFFFF : quot[15:0];
   end

endmodule

`default_nettype wire

/* hw/rtl/bhsc_core.sv */
// ----------------------------------------------------------------------------
// BLDC hall commutator core
// Updates the motor state for one item per cycle unless the result stalls; the state is the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhsc_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bhsc_pkg::bhsc_cfg_type      cfg,
   input  wire logic                        item_valid,
   input  wire bhsc_pkg::bhsc_req_item_type item,
   output logic                             item_take,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output bhsc_pkg::bhsc_rsp_item_type      rsp_data
);
   import bhsc_pkg::*;

   logic        rsp_valid_ff;
   logic [1:0]  mode_ff,     mode_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [15:0] stall_ff,    stall_in;
   logic [2:0]  last_hall_ff, last_hall_in;
   logic [5:0]  drives_ff,   drives_in;
   logic        gate_ff,     gate_in;
   logic [15:0] compare_ff,  compare_in;

   logic [7:0]  attempts_inc;
   logic [15:0] stall_inc;
   logic [2:0]  sel;
   logic [1:0]  mode_mid;
   logic        fire;

   // The result register is free when empty or being taken.
   assign item_take = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && item_take;

   // Next state for one item.
   always_comb begin
      mode_in      = mode_ff;
      attempts_in  = attempts_ff;
      stall_in     = stall_ff;
      last_hall_in = last_hall_ff;
      drives_in    = drives_ff;
      gate_in      = gate_ff;
      compare_in   = compare_ff;
      mode_mid     = mode_ff;

      attempts_inc = attempts_ff + 8'd1;
      stall_inc    = stall_ff + 16'd1;
      sel          = cfg.direction ? ~item.hall_code : item.hall_code;

      if (item.req_type == REQ_CONTROL) begin
         if (mode_ff == MODE_STOP) begin
            drives_in = '0;
            gate_in   = 1'b0;
         end else begin
            // Start attempt count, compare load and gate enable.
            if (mode_ff == MODE_START) begin
               attempts_in = attempts_inc;
               if (attempts_inc > cfg.start_limit) begin
                  mode_mid    = MODE_STOP;
                  attempts_in = '0;
               end
               compare_in = cfg.compare;
               gate_in    = 1'b1;
            end
            mode_in = mode_mid;
            // Commutation, skipped on the pass that fails the start.
            if (mode_mid != MODE_STOP) begin
               if (last_hall_ff != item.hall_code) begin
                  mode_in      = MODE_RUN;
                  last_hall_in = item.hall_code;
               end
               drives_in = six_step(sel);
               stall_in  = '0;
            end
         end
      end else if (mode_ff == MODE_RUN) begin
         // Millisecond tick: stall timeout.
         stall_in = stall_inc;
         if (stall_inc > cfg.stall_limit) begin
            drives_in = '0;
            gate_in   = 1'b0;
            mode_in   = MODE_STOP;
            stall_in  = '0;
         end
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_START;
         attempts_ff  <= '0;
         stall_ff     <= '0;
         last_hall_ff <= RST_LAST_HALL;
         drives_ff    <= '0;
         gate_ff      <= 1'b0;
         compare_ff   <= '0;
      end else begin
         if (item_take) begin
            rsp_valid_ff <= item_valid;
         end
         if (fire) begin
            mode_ff      <= mode_in;
            attempts_ff  <= attempts_in;
            stall_ff     <= stall_in;
            last_hall_ff <= last_hall_in;
            drives_ff    <= drives_in;
            gate_ff      <= gate_in;
            compare_ff   <= compare_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.drive_u_high = drives_ff[DRV_UH];
      rsp_data.drive_u_low  = drives_ff[DRV_UL];
      rsp_data.drive_v_high = drives_ff[DRV_VH];
      rsp_data.drive_v_low  = drives_ff[DRV_VL];
      rsp_data.drive_w_high = drives_ff[DRV_WH];
      rsp_data.drive_w_low  = drives_ff[DRV_WL];
      rsp_data.gate_enable  = gate_ff;
      rsp_data.duty_compare = compare_ff;
      rsp_data.motor_mode   = mode_ff;
   end

endmodule

`default_nettype wire
